[rtl/core/first_fit_boundary_tag_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit_macros
// assertion helpers clocked on clock and disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FFBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants, mode codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package ffba_pkg;

   // tag geometry
   localparam int WORD_BYTES  = 4;
   localparam int ALIGN_BYTES = 2 * WORD_BYTES;
   localparam int MIN_BLOCK   = 2 * ALIGN_BYTES;

   // field widths
   localparam int MODE_W = 2;
   localparam int REQ_W  = 15;
   localparam int OFF_W  = 14;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESIZE  = 2'd2;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TAKE,
      OP_DISP,
      OP_WRD,
      OP_WCHK,
      OP_HDR,
      OP_HDR_PEAK,
      OP_FTR,
      OP_FTR_SPLIT,
      OP_FTR_RDNX,
      OP_CRD,
      OP_CTAG,
      OP_CFTR,
      OP_RINIT,
      OP_NX,
      OP_RPV,
      OP_PV,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic              clr_last;
      logic [MODE_W-1:0] mode;
      logic              n_zero;
      logic              p_zero;
      logic              p_ok;
      logic              walk_in;
      logic              sz_small;
      logic              fit;
      logic              split;
      logic              reloc;
      logic              tag_ok;
      logic              ftr_ok;
      logic              n_le_cur;
      logic              nx_merge;
      logic              pv_merge;
      logic              out_free;
   } sts_type;

endpackage

[rtl/core/ffba_if.sv]
// ----------------------------------------------------------------------------
// ffba_if
// valid/ready channels for allocator requests and responses
// ----------------------------------------------------------------------------
interface ffba_req_if;
   logic                        valid;
   logic                        ready;
   logic [ffba_pkg::MODE_W-1:0] mode;
   logic [ffba_pkg::REQ_W-1:0]  request_bytes;
   logic [ffba_pkg::OFF_W-1:0]  payload_offset;

   modport source (output valid, mode, request_bytes, payload_offset, input ready);
   modport sink   (input valid, mode, request_bytes, payload_offset, output ready);
endinterface

interface ffba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ffba_pkg::OFF_W-1:0] result_offset;
   logic [ffba_pkg::OFF_W-1:0] copy_bytes;
   logic [ffba_pkg::OFF_W-1:0] used_bytes;
   logic [ffba_pkg::OFF_W-1:0] peak_bytes;

   modport source (output valid, result_offset, copy_bytes, used_bytes, peak_bytes,
                   input ready);
   modport sink   (input valid, result_offset, copy_bytes, used_bytes, peak_bytes,
                   output ready);
endinterface

[rtl/core/ffba_datapath.sv]
// ----------------------------------------------------------------------------
// ffba_datapath
// tag memory, walk and block registers, usage counters and response register
// ----------------------------------------------------------------------------
module ffba_datapath #(
   parameter int ARENA_BYTES = 16384
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ffba_pkg::cmd_type           cmd,
   input  logic [ffba_pkg::MODE_W-1:0] req_mode,
   input  logic [ffba_pkg::REQ_W-1:0]  req_bytes,
   input  logic [ffba_pkg::OFF_W-1:0]  req_offset,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [ffba_pkg::OFF_W-1:0]  rsp_result,
   output logic [ffba_pkg::OFF_W-1:0]  rsp_copy,
   output logic [ffba_pkg::OFF_W-1:0]  rsp_used,
   output logic [ffba_pkg::OFF_W-1:0]  rsp_peak,
   output ffba_pkg::sts_type           sts
);

   localparam int TW          = $clog2(ARENA_BYTES);
   localparam int DW          = ($clog2(ARENA_BYTES) + 2 > 17) ? $clog2(ARENA_BYTES) + 2 : 17;
   localparam int STORE_WORDS = ARENA_BYTES / ffba_pkg::WORD_BYTES;
   localparam int IW          = $clog2(STORE_WORDS);
   localparam int ARENA_STOP  = (ARENA_BYTES / ffba_pkg::ALIGN_BYTES) * ffba_pkg::ALIGN_BYTES;
   localparam int EPI_OFF     = ARENA_STOP - ffba_pkg::WORD_BYTES;
   localparam int FREE_SIZE   = EPI_OFF - ffba_pkg::WORD_BYTES;
   localparam int EPI_IDX     = EPI_OFF / ffba_pkg::WORD_BYTES;
   localparam int FTR_IDX     = EPI_IDX - 1;
   localparam int HDR_IDX     = 1;

   localparam logic [DW-1:0] EPI_X   = DW'(EPI_OFF);
   localparam logic [DW-1:0] WORD_X  = DW'(ffba_pkg::WORD_BYTES);
   localparam logic [DW-1:0] ALIGN_X = DW'(ffba_pkg::ALIGN_BYTES);
   localparam logic [DW-1:0] AMASK_X = DW'(ffba_pkg::ALIGN_BYTES - 1);
   localparam logic [DW-1:0] MIN_X   = DW'(ffba_pkg::MIN_BLOCK);
   localparam logic [DW-1:0] TAGS_X  = DW'(2 * ffba_pkg::WORD_BYTES);

   // tag memory
   logic [TW-1:0] mem [STORE_WORDS];
   logic [TW-1:0] rd_ff;
   logic [IW-1:0] ra;
   logic [IW-1:0] wa;
   logic [TW-1:0] wd;
   logic          we;

   // working registers
   logic [ffba_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [ffba_pkg::REQ_W-1:0]  n_ff, n_in;
   logic [ffba_pkg::OFF_W-1:0]  p_ff, p_in;
   logic [DW-1:0] need_ff, need_in;
   logic [DW-1:0] walk_ff, walk_in;
   logic [DW-1:0] blk_ff, blk_in;
   logic [TW-1:0] tag_ff, tag_in;
   logic [DW-1:0] base_ff, base_in;
   logic [DW-1:0] size_ff, size_in;
   logic [DW-1:0] spare_ff, spare_in;
   logic          abit_ff, abit_in;
   logic          split_ff, split_in;
   logic          reloc_ff, reloc_in;
   logic [DW-1:0] res_ff, res_in;
   logic [DW-1:0] copy_ff, copy_in;
   logic [TW-1:0] used_ff, used_in;
   logic [TW-1:0] peak_ff, peak_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic          ovalid_ff, ovalid_in;
   logic [ffba_pkg::OFF_W-1:0] ores_ff, ores_in;
   logic [ffba_pkg::OFF_W-1:0] ocopy_ff, ocopy_in;
   logic [ffba_pkg::OFF_W-1:0] oused_ff, oused_in;
   logic [ffba_pkg::OFF_W-1:0] opeak_ff, opeak_in;

   // decoded tag fields
   logic [DW-1:0] rd_sz;
   logic [DW-1:0] tag_sz;
   logic [DW-1:0] cur;
   logic [DW-1:0] nx_off;
   logic [DW-1:0] ftr_off;
   logic [DW-1:0] need_raw;
   logic [DW-1:0] ra_off;
   logic [DW-1:0] fit_size;
   logic [TW-1:0] init_val;

   assign rd_sz    = DW'({rd_ff[TW-1:1], 1'b0});
   assign tag_sz   = DW'({tag_ff[TW-1:1], 1'b0});
   assign cur      = tag_sz - TAGS_X;
   assign nx_off   = base_ff + size_ff;
   assign ftr_off  = base_ff + size_ff - WORD_X;
   assign need_raw = (DW'(req_bytes) + TAGS_X + AMASK_X) & ~AMASK_X;
   assign fit_size = sts.split ? need_ff : rd_sz;

   // status toward the controller
   always_comb begin
      sts.clr_last = (clr_ff == IW'(STORE_WORDS - 1));
      sts.mode     = mode_ff;
      sts.n_zero   = (n_ff == '0);
      sts.p_zero   = (p_ff == '0);
      sts.p_ok     = ((DW'(p_ff) & AMASK_X) == '0) && (DW'(p_ff) >= ALIGN_X)
                     && ((DW'(p_ff) - WORD_X) < EPI_X);
      sts.walk_in  = (walk_ff < EPI_X);
      sts.sz_small = (rd_sz < ALIGN_X);
      sts.fit      = !rd_ff[0] && (rd_sz >= need_ff);
      sts.split    = (rd_sz - need_ff) >= MIN_X;
      sts.reloc    = reloc_ff;
      sts.tag_ok   = rd_ff[0] && (rd_sz >= MIN_X) && ((rd_sz & AMASK_X) == '0)
                     && (rd_sz <= EPI_X - blk_ff);
      sts.ftr_ok   = (rd_ff == tag_ff);
      sts.n_le_cur = (DW'(n_ff) <= cur);
      sts.nx_merge = (nx_off < EPI_X) && !rd_ff[0];
      sts.pv_merge = !rd_ff[0] && (rd_sz <= base_ff) && ((base_ff - rd_sz) >= WORD_X);
      sts.out_free = !ovalid_ff || rsp_ready;
   end

   // split flag for the footer step is the one captured at the fit
   logic split_use;
   assign split_use = split_ff;

   // reset image of one tag word during the clearing pass
   always_comb begin
      if (clr_ff == '0) begin
         init_val = TW'(1);
      end else if (clr_ff == IW'(HDR_IDX) || clr_ff == IW'(FTR_IDX)) begin
         init_val = TW'(FREE_SIZE);
      end else if (clr_ff == IW'(EPI_IDX)) begin
         init_val = TW'(1);
      end else begin
         init_val = '0;
      end
   end

   // memory address and write selection
   always_comb begin
      case (cmd.op)
         ffba_pkg::OP_CRD:      ra_off = blk_ff;
         ffba_pkg::OP_CTAG:     ra_off = blk_ff + rd_sz - WORD_X;
         ffba_pkg::OP_FTR_RDNX: ra_off = nx_off;
         ffba_pkg::OP_RPV:      ra_off = base_ff - WORD_X;
         default:               ra_off = walk_ff;
      endcase
      ra = ra_off[IW+1:2];
      we = 1'b0;
      wa = base_ff[IW+1:2];
      wd = TW'(size_ff) | TW'(abit_ff);
      case (cmd.op)
         ffba_pkg::OP_CLEAR: begin
            we = 1'b1;
            wa = clr_ff;
            wd = init_val;
         end
         ffba_pkg::OP_HDR, ffba_pkg::OP_HDR_PEAK: begin
            we = 1'b1;
         end
         ffba_pkg::OP_FTR, ffba_pkg::OP_FTR_SPLIT, ffba_pkg::OP_FTR_RDNX: begin
            we = 1'b1;
            wa = ftr_off[IW+1:2];
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   // tag memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   // next values per operation
   always_comb begin
      mode_in   = mode_ff;
      n_in      = n_ff;
      p_in      = p_ff;
      need_in   = need_ff;
      walk_in   = walk_ff;
      blk_in    = blk_ff;
      tag_in    = tag_ff;
      base_in   = base_ff;
      size_in   = size_ff;
      spare_in  = spare_ff;
      abit_in   = abit_ff;
      split_in  = split_ff;
      reloc_in  = reloc_ff;
      res_in    = res_ff;
      copy_in   = copy_ff;
      used_in   = used_ff;
      peak_in   = peak_ff;
      clr_in    = clr_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      ores_in   = ores_ff;
      ocopy_in  = ocopy_ff;
      oused_in  = oused_ff;
      opeak_in  = opeak_ff;
      case (cmd.op)
         ffba_pkg::OP_CLEAR: begin
            clr_in = clr_ff + IW'(1);
         end
         ffba_pkg::OP_TAKE: begin
            mode_in  = req_mode;
            n_in     = req_bytes;
            p_in     = req_offset;
            need_in  = (need_raw < MIN_X) ? MIN_X : need_raw;
            res_in   = '0;
            copy_in  = '0;
            reloc_in = 1'b0;
         end
         ffba_pkg::OP_DISP: begin
            walk_in = WORD_X;
            blk_in  = DW'(p_ff) - WORD_X;
         end
         ffba_pkg::OP_WCHK: begin
            if (sts.fit) begin
               base_in  = walk_ff;
               abit_in  = 1'b1;
               size_in  = fit_size;
               spare_in = rd_sz - need_ff;
               split_in = sts.split;
               used_in  = used_ff + TW'(fit_size);
               res_in   = walk_ff + WORD_X;
               if (reloc_ff) begin
                  copy_in = cur;
               end
            end else begin
               walk_in = walk_ff + rd_sz;
            end
         end
         ffba_pkg::OP_HDR_PEAK: begin
            peak_in = (used_ff > peak_ff) ? used_ff : peak_ff;
         end
         ffba_pkg::OP_FTR_SPLIT: begin
            if (split_use) begin
               base_in = nx_off;
               size_in = spare_ff;
               abit_in = 1'b0;
            end
         end
         ffba_pkg::OP_CTAG: begin
            tag_in = rd_ff;
         end
         ffba_pkg::OP_CFTR: begin
            if (sts.ftr_ok && mode_ff == ffba_pkg::MODE_RESIZE && !sts.n_zero) begin
               if (sts.n_le_cur) begin
                  res_in = DW'(p_ff);
               end else begin
                  reloc_in = 1'b1;
               end
            end
         end
         ffba_pkg::OP_RINIT: begin
            used_in = (DW'(used_ff) >= tag_sz) ? used_ff - TW'(tag_sz) : '0;
            base_in = blk_ff;
            size_in = tag_sz;
            abit_in = 1'b0;
         end
         ffba_pkg::OP_NX: begin
            if (sts.nx_merge) begin
               size_in = size_ff + rd_sz;
            end
         end
         ffba_pkg::OP_PV: begin
            if (sts.pv_merge) begin
               base_in = base_ff - rd_sz;
               size_in = size_ff + rd_sz;
            end
         end
         ffba_pkg::OP_OUT: begin
            ovalid_in = 1'b1;
            ores_in   = ffba_pkg::OFF_W'(res_ff);
            ocopy_in  = ffba_pkg::OFF_W'(copy_ff);
            oused_in  = ffba_pkg::OFF_W'(used_ff);
            opeak_in  = ffba_pkg::OFF_W'(peak_ff);
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         peak_ff   <= '0;
         clr_ff    <= '0;
         ovalid_ff <= 1'b0;
         reloc_ff  <= 1'b0;
      end else begin
         used_ff   <= used_in;
         peak_ff   <= peak_in;
         clr_ff    <= clr_in;
         ovalid_ff <= ovalid_in;
         reloc_ff  <= reloc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      n_ff     <= n_in;
      p_ff     <= p_in;
      need_ff  <= need_in;
      walk_ff  <= walk_in;
      blk_ff   <= blk_in;
      tag_ff   <= tag_in;
      base_ff  <= base_in;
      size_ff  <= size_in;
      spare_ff <= spare_in;
      abit_ff  <= abit_in;
      split_ff <= split_in;
      res_ff   <= res_in;
      copy_ff  <= copy_in;
      ores_ff  <= ores_in;
      ocopy_ff <= ocopy_in;
      oused_ff <= oused_in;
      opeak_ff <= opeak_in;
   end

   assign rsp_valid  = ovalid_ff;
   assign rsp_result = ores_ff;
   assign rsp_copy   = ocopy_ff;
   assign rsp_used   = oused_ff;
   assign rsp_peak   = opeak_ff;

endmodule

[rtl/core/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer for clearing, first-fit walk, block checks, release and merge
// ----------------------------------------------------------------------------
module ffba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffba_pkg::sts_type sts,
   output ffba_pkg::cmd_type cmd
);

   typedef enum logic [22:0] {
      ST_CLEAR = 23'h1 << 0,
      ST_IDLE  = 23'h1 << 1,
      ST_DISP  = 23'h1 << 2,
      ST_WRD   = 23'h1 << 3,
      ST_WCHK  = 23'h1 << 4,
      ST_APH   = 23'h1 << 5,
      ST_APF   = 23'h1 << 6,
      ST_ASH   = 23'h1 << 7,
      ST_ASF   = 23'h1 << 8,
      ST_CRD   = 23'h1 << 9,
      ST_CTAG  = 23'h1 << 10,
      ST_CFTR  = 23'h1 << 11,
      ST_RINIT = 23'h1 << 12,
      ST_RPH   = 23'h1 << 13,
      ST_RPF   = 23'h1 << 14,
      ST_RNX   = 23'h1 << 15,
      ST_RMH   = 23'h1 << 16,
      ST_RMF   = 23'h1 << 17,
      ST_RPV   = 23'h1 << 18,
      ST_RPC   = 23'h1 << 19,
      ST_RQH   = 23'h1 << 20,
      ST_RQF   = 23'h1 << 21,
      ST_DONE  = 23'h1 << 22
   } state_type;

   state_type state_ff, state_in;
   logic      after_alloc_reloc;

   assign req_ready         = (state_ff == ST_IDLE);
   assign after_alloc_reloc = sts.reloc;

   // next state and datapath operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = ffba_pkg::OP_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = ffba_pkg::OP_CLEAR;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = ffba_pkg::OP_TAKE;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            cmd.op = ffba_pkg::OP_DISP;
            case (sts.mode)
               ffba_pkg::MODE_ALLOC: begin
                  state_in = sts.n_zero ? ST_DONE : ST_WRD;
               end
               ffba_pkg::MODE_RELEASE: begin
                  state_in = sts.p_ok ? ST_CRD : ST_DONE;
               end
               ffba_pkg::MODE_RESIZE: begin
                  if (sts.p_zero) begin
                     state_in = sts.n_zero ? ST_DONE : ST_WRD;
                  end else begin
                     state_in = sts.p_ok ? ST_CRD : ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         // first-fit walk: each block header is read in ST_WRD and checked in ST_WCHK
         ST_WRD: begin
            cmd.op   = ffba_pkg::OP_WRD;
            state_in = sts.walk_in ? ST_WCHK : ST_DONE;
         end
         ST_WCHK: begin
            cmd.op = ffba_pkg::OP_WCHK;
            if (sts.sz_small) begin
               state_in = ST_DONE;
            end else if (sts.fit) begin
               state_in = ST_APH;
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_APH: begin
            cmd.op   = ffba_pkg::OP_HDR_PEAK;
            state_in = ST_APF;
         end
         ST_APF: begin
            cmd.op = ffba_pkg::OP_FTR_SPLIT;
            if (sts.split) begin
               state_in = ST_ASH;
            end else begin
               state_in = after_alloc_reloc ? ST_RINIT : ST_DONE;
            end
         end
         ST_ASH: begin
            cmd.op   = ffba_pkg::OP_HDR;
            state_in = ST_ASF;
         end
         ST_ASF: begin
            cmd.op   = ffba_pkg::OP_FTR;
            state_in = after_alloc_reloc ? ST_RINIT : ST_DONE;
         end
         // block check: header, then footer
         ST_CRD: begin
            cmd.op   = ffba_pkg::OP_CRD;
            state_in = ST_CTAG;
         end
         ST_CTAG: begin
            cmd.op   = ffba_pkg::OP_CTAG;
            state_in = sts.tag_ok ? ST_CFTR : ST_DONE;
         end
         ST_CFTR: begin
            cmd.op = ffba_pkg::OP_CFTR;
            if (!sts.ftr_ok) begin
               state_in = ST_DONE;
            end else if (sts.mode == ffba_pkg::MODE_RELEASE || sts.n_zero) begin
               state_in = ST_RINIT;
            end else if (sts.n_le_cur) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WRD;
            end
         end
         // release and merge with neighbors
         ST_RINIT: begin
            cmd.op   = ffba_pkg::OP_RINIT;
            state_in = ST_RPH;
         end
         ST_RPH: begin
            cmd.op   = ffba_pkg::OP_HDR;
            state_in = ST_RPF;
         end
         ST_RPF: begin
            cmd.op   = ffba_pkg::OP_FTR_RDNX;
            state_in = ST_RNX;
         end
         ST_RNX: begin
            cmd.op   = ffba_pkg::OP_NX;
            state_in = sts.nx_merge ? ST_RMH : ST_RPV;
         end
         ST_RMH: begin
            cmd.op   = ffba_pkg::OP_HDR;
            state_in = ST_RMF;
         end
         ST_RMF: begin
            cmd.op   = ffba_pkg::OP_FTR;
            state_in = ST_RPV;
         end
         ST_RPV: begin
            cmd.op   = ffba_pkg::OP_RPV;
            state_in = ST_RPC;
         end
         ST_RPC: begin
            cmd.op   = ffba_pkg::OP_PV;
            state_in = sts.pv_merge ? ST_RQH : ST_DONE;
         end
         ST_RQH: begin
            cmd.op   = ffba_pkg::OP_HDR;
            state_in = ST_RQF;
         end
         ST_RQF: begin
            cmd.op   = ffba_pkg::OP_FTR;
            state_in = ST_DONE;
         end
         // hand the item to the response register
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.op   = ffba_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/first_fit_boundary_tag_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit
// first-fit allocator over an arena of header/footer tagged blocks
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  req_ch   | in  | mode, request_bytes, payload_offset
//  rsp_ch   | out | result_offset, copy_bytes, used_bytes, peak_bytes
//
//  allocate: a header read and check per block visited on the first-fit walk, then 2 to 4 tag writes
//  release: block check, then tag writes and merges with free neighbours; a relocating resize is the sum of both
//  the walk reads each block header through the single tag memory read port
//  after reset a clearing pass over all ARENA_BYTES/4 tag words (4096 by default) runs
//  a waiting item in the response register does not block the next request
// ----------------------------------------------------------------------------
`include "first_fit_boundary_tag_allocator_unit_macros.svh"

module first_fit_boundary_tag_allocator_unit #(
   parameter int ARENA_BYTES = 16384
) (
   input logic       clock,
   input logic       reset,
   ffba_req_if.sink  req_ch,
   ffba_rsp_if.source rsp_ch
);

   ffba_pkg::cmd_type cmd;
   ffba_pkg::sts_type sts;

   // sequencer
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tag memory and arithmetic
   ffba_datapath #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_mode   (req_ch.mode),
      .req_bytes  (req_ch.request_bytes),
      .req_offset (req_ch.payload_offset),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_result (rsp_ch.result_offset),
      .rsp_copy   (rsp_ch.copy_bytes),
      .rsp_used   (rsp_ch.used_bytes),
      .rsp_peak   (rsp_ch.peak_bytes),
      .sts        (sts)
   );

   // an accepted item makes the unit busy in the following cycle
   `FFBA_ASSERT_NEXT(a_take_then_busy, req_ch.valid && req_ch.ready, !req_ch.ready)
   // a new response is only produced after a busy cycle
   `FFBA_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_ch.valid), !$past(req_ch.ready))
   // the clearing pass holds off requests right after reset
   `FFBA_ASSERT_NOW(a_clear_after_reset, $past(reset), !req_ch.ready)

endmodule
